// ----- hdl/lhm_pkg.sv -----
// Shared types, codes and defaults for the linear probing hash map.
package lhm_pkg;

  // Default table size and reset value of the occupancy limit (three quarters of 256).
  localparam int unsigned SLOT_COUNT_DEFAULT = 256;
  localparam logic [7:0]  MAX_OCC_RESET      = 8'd192;

  // Request operation codes.
  localparam logic [1:0] REQ_SET = 2'd0;
  localparam logic [1:0] REQ_GET = 2'd1;
  localparam logic [1:0] REQ_DEL = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  // Slot state codes.
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key_id;
    logic [31:0] key_hash;
    logic [63:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_new_key;
    logic [63:0] value_out;
    logic [8:0]  occupancy;
  } rsp_t;

  // One stored slot: state, key and value held together in one memory word.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [63:0] value;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // Classification of one slot against the key being probed for.
  typedef struct packed {
    logic live_match;
    logic tomb;
    logic empty;
  } slot_class_t;

endpackage

// ----- hdl/lhm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lhm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/lhm_slot_cmp.sv -----
// Classifies one slot read from the table against the key being probed for.
module lhm_slot_cmp (
  input  lhm_pkg::slot_t       slot,
  input  logic [31:0]          key_id,
  output lhm_pkg::slot_class_t cls
);
  import lhm_pkg::*;

  // A live slot matches only on an equal key; unknown state codes count as neither.
  always_comb begin
    cls.live_match = (slot.kind == SLOT_LIVE) && (slot.key == key_id);
    cls.tomb       = (slot.kind == SLOT_TOMB);
    cls.empty      = (slot.kind == SLOT_EMPTY);
  end

endmodule

// ----- hdl/lhm_start_idx.sv -----
// Reduces a key hash modulo the slot count to give the first slot of a probe.
module lhm_start_idx #(
  parameter int unsigned SLOT_COUNT = lhm_pkg::SLOT_COUNT_DEFAULT,
  parameter int unsigned IDX_W      = $clog2(SLOT_COUNT)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      key_hash,
  output logic             done,
  output logic [IDX_W-1:0] idx
);

  if ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0) begin : g_pow2
    // A power-of-two table takes the low hash bits directly.
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
      if (start) begin
        idx <= key_hash[IDX_W-1:0];
      end
    end
  end else begin : g_recip
    localparam logic [31:0]    RECIP   = 32'(64'h1_0000_0000 / 64'(SLOT_COUNT));
    localparam logic [31:0]    MOD32   = 32'(SLOT_COUNT);
    localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(SLOT_COUNT);

    logic [31:0]    hash_r;
    logic [31:0]    quot;
    logic [IDX_W:0] rest;
    logic [31:0]    mul_a;
    logic [31:0]    mul_b;
    logic [63:0]    prod;
    logic [31:0]    diff;
    logic           step1;
    logic           step2;
    logic           step3;

    // One shared multiplier: first the hash by the reciprocal, then the quotient by the modulus.
    assign mul_a = step1 ? hash_r : quot;
    assign mul_b = step1 ? RECIP : MOD32;
    assign prod  = {32'd0, mul_a} * {32'd0, mul_b};
    assign diff  = hash_r - prod[31:0];

    // The estimated quotient is at most one short, so one conditional subtraction finishes it.
    always_ff @(posedge clk) begin
      if (rst) begin
        step1 <= 1'b0;
        step2 <= 1'b0;
        step3 <= 1'b0;
        done  <= 1'b0;
      end else begin
        step1 <= start;
        step2 <= step1;
        step3 <= step2;
        done  <= step3;
      end
      if (start) begin
        hash_r <= key_hash;
      end
      if (step1) begin
        quot <= prod[63:32];
      end
      if (step2) begin
        rest <= diff[IDX_W:0];
      end
      if (step3) begin
        idx <= (rest >= MODULUS) ? IDX_W'(rest - MODULUS) : rest[IDX_W-1:0];
      end
    end
  end

endmodule

// ----- hdl/linear_probe_hash_map.sv -----
// Top level of the linear probing hash map: sequencer, table memory and occupancy count.
//
// Open-addressing key/value table with linear probing and tombstones. A request is taken
// when start is high and busy is low; its result appears on rsp with done high for exactly
// one cycle, and cannot be held off by the receiver. After reset the block clears the
// slot states, one slot per cycle, and stays busy meanwhile; max_occupancy may be
// written at any time. A set rejected by the occupancy limit, or an unknown request
// type, answers in the cycle after it is taken. Any other request walks the table
// through the single memory read port, one slot per cycle, until it finds the key or an
// empty slot or has visited every slot; when SLOT_COUNT is not a power of two the start
// slot comes from a reciprocal multiplication with one correction step.
module linear_probe_hash_map #(
  parameter int unsigned SLOT_COUNT = lhm_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lhm_pkg::req_t req,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  output logic          done,
  output lhm_pkg::rsp_t rsp
);
  import lhm_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_INDEX, S_PROBE} state_t;
  typedef enum logic [1:0] {HIT_LIVE, HIT_TOMB, HIT_EMPTY, HIT_NONE} hit_t;

  state_t           state;
  req_t             req_r;
  logic [7:0]       max_occ;
  logic [8:0]       occ;
  logic [8:0]       occ_next;
  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] eval_addr;
  logic [IDX_W-1:0] tomb_addr;
  logic [CNT_W-1:0] n;
  logic             rd_vld;
  logic             have_tomb;

  logic             idx_go;
  logic             idx_done;
  logic [IDX_W-1:0] idx_start;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_t            ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t            slot_rd;
  slot_class_t      cls;

  logic             full_now;
  logic             needs_probe;
  logic             last;
  logic             first_tomb;
  logic             tomb_any;
  logic             finish;
  hit_t             hit;
  logic [IDX_W-1:0] where;
  rsp_t             rsp_next;
  logic             wr_slot;
  slot_t            wr_slot_data;

  // Next slot along the probe, wrapping at the end of the table.
  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] a);
    return (a == LAST_IDX) ? '0 : a + 1'b1;
  endfunction

  assign busy = (state != S_IDLE);

  // Load check happens before any probe; only sets that pass it, lookups and deletes walk the table.
  assign full_now    = (10'(occ) + 10'd1) > 10'(max_occ);
  assign needs_probe = ((req.req_type == REQ_SET) && !full_now) ||
                       (req.req_type == REQ_GET) || (req.req_type == REQ_DEL);
  assign idx_go      = start && !busy && needs_probe;

  lhm_start_idx #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_start_idx (
    .clk      (clk),
    .rst      (rst),
    .start    (idx_go),
    .key_hash (req.key_hash),
    .done     (idx_done),
    .idx      (idx_start)
  );

  lhm_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_rd = slot_t'(ram_rdata);

  lhm_slot_cmp u_cmp (
    .slot   (slot_rd),
    .key_id (req_r.key_id),
    .cls    (cls)
  );

  // The first read is issued straight from the start slot; later reads run one slot ahead.
  assign ram_raddr = (state == S_INDEX) ? idx_start : rd_addr;

  // Probe decision for the slot whose data has just arrived.
  always_comb begin
    last       = (n == CNT_W'(SLOT_COUNT - 1));
    first_tomb = cls.tomb && !have_tomb;
    tomb_any   = have_tomb || cls.tomb;
    finish     = (state == S_PROBE) && rd_vld && (cls.live_match || cls.empty || last);
    where      = eval_addr;
    if (cls.live_match) begin
      hit = HIT_LIVE;
    end else if (tomb_any) begin
      hit   = HIT_TOMB;
      where = have_tomb ? tomb_addr : eval_addr;
    end else if (cls.empty) begin
      hit = HIT_EMPTY;
    end else begin
      hit = HIT_NONE;
    end
  end

  // Result and table update for a finished probe.
  always_comb begin
    occ_next             = occ;
    wr_slot              = 1'b0;
    wr_slot_data         = slot_rd;
    rsp_next.status      = STATUS_NOT_FOUND;
    rsp_next.is_new_key  = 1'b0;
    rsp_next.value_out   = '0;
    case (req_r.req_type)
      REQ_SET: begin
        if (hit == HIT_NONE) begin
          rsp_next.status = STATUS_FULL;
        end else begin
          rsp_next.status     = STATUS_OK;
          rsp_next.is_new_key = (hit != HIT_LIVE);
          wr_slot             = 1'b1;
          wr_slot_data.kind   = SLOT_LIVE;
          wr_slot_data.key    = req_r.key_id;
          wr_slot_data.value  = req_r.value_in;
          if (hit == HIT_EMPTY) begin
            occ_next = occ + 9'd1;
          end
        end
      end
      REQ_GET: begin
        if (hit == HIT_LIVE) begin
          rsp_next.status    = STATUS_OK;
          rsp_next.value_out = slot_rd.value;
        end
      end
      REQ_DEL: begin
        if (hit == HIT_LIVE) begin
          rsp_next.status   = STATUS_OK;
          wr_slot           = 1'b1;
          wr_slot_data.kind = SLOT_TOMB;
        end
      end
      default: begin
        rsp_next.status = STATUS_NOT_FOUND;
      end
    endcase
    rsp_next.occupancy = occ_next;
  end

  // Table write port: the clearing pass after reset, else the update of a finished probe.
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we          = 1'b1;
      ram_waddr       = clr_addr;
      ram_wdata.kind  = SLOT_EMPTY;
      ram_wdata.key   = '0;
      ram_wdata.value = '0;
    end else begin
      ram_we    = finish && wr_slot;
      ram_waddr = where;
      ram_wdata = wr_slot_data;
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      done      <= 1'b0;
      max_occ   <= MAX_OCC_RESET;
      occ       <= '0;
      rd_vld    <= 1'b0;
      have_tomb <= 1'b0;
    end else begin
      done <= ((state == S_IDLE) && start && !needs_probe) || finish;
      if (cfg_we) begin
        max_occ <= cfg_wdata;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= inc_idx(clr_addr);
          if (clr_addr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req_r <= req;
            if (needs_probe) begin
              state <= S_INDEX;
            end else begin
              rsp.status     <= (req.req_type == REQ_SET) ? STATUS_FULL : STATUS_NOT_FOUND;
              rsp.is_new_key <= 1'b0;
              rsp.value_out  <= '0;
              rsp.occupancy  <= occ;
            end
          end
        end
        S_INDEX: begin
          if (idx_done) begin
            rd_addr   <= inc_idx(idx_start);
            eval_addr <= idx_start;
            rd_vld    <= 1'b1;
            n         <= '0;
            have_tomb <= 1'b0;
            state     <= S_PROBE;
          end
        end
        S_PROBE: begin
          rd_addr   <= inc_idx(rd_addr);
          eval_addr <= rd_addr;
          if (rd_vld) begin
            n <= n + 1'b1;
            if (first_tomb) begin
              have_tomb <= 1'b1;
              tomb_addr <= eval_addr;
            end
          end
          if (finish) begin
            rsp    <= rsp_next;
            occ    <= occ_next;
            rd_vld <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The occupied count can never exceed the number of slots.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= SLOT_COUNT)
    else $error("occupied count exceeds slot count");

  // The occupied count only ever grows, and by one at a time.
  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (occ != $past(occ))) |-> (occ == $past(occ) + 9'd1))
    else $error("occupied count changed by other than one");

  // A probe never evaluates more slots than the table holds.
  a_probe_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (32'(n) < SLOT_COUNT))
    else $error("probe ran past the table length");

  // A full status is only ever given to a set.
  a_full_set: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == STATUS_FULL)) |-> (req_r.req_type == REQ_SET))
    else $error("full status on a request that is not a set");

  // A result follows either an immediate answer or the end of a probe.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst)) |-> ($past(state == S_IDLE) || $past(state == S_PROBE)))
    else $error("result strobe without a request behind it");

endmodule

// ----- tb/sv/lhm_checker.sv -----
// Response checker for the hash map: mirrors the table, predicts every response and compares it.
module lhm_checker #(
  parameter int unsigned SLOTS = lhm_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  lhm_pkg::req_t req,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  input  logic          done,
  input  lhm_pkg::rsp_t rsp,
  output int unsigned   mismatches,
  output int unsigned   outstanding,
  output int unsigned   responses
);
  timeunit 1ns;
  timeprecision 1ps;
  import lhm_pkg::*;

  // How a walk along the table ended.
  typedef enum logic [1:0] {
    WALK_LIVE,
    WALK_TOMB,
    WALK_EMPTY,
    WALK_NONE
  } walk_end_t;

  // Mirror of the table contents, the occupied count and the limit register.
  logic [1:0]  slot_kind [SLOTS];
  logic [31:0] slot_key  [SLOTS];
  logic [63:0] slot_val  [SLOTS];
  logic [8:0]  occ_count;
  logic [7:0]  occ_limit;

  // Responses still owed by the block, oldest first.
  rsp_t awaited_q [$];

  // Walk from the start slot until the key or an empty slot turns up, noting the first tombstone.
  function automatic walk_end_t walk_table(input logic [31:0] key, input logic [31:0] hash,
                                           output int unsigned where);
    int unsigned idx;
    int unsigned tomb_at;
    bit          seen_tomb;
    idx       = hash % SLOTS;
    tomb_at   = 0;
    seen_tomb = 1'b0;
    where     = 0;
    for (int unsigned n = 0; n < SLOTS; n++) begin
      if (slot_kind[idx] == SLOT_LIVE) begin
        if (slot_key[idx] == key) begin
          where = idx;
          return WALK_LIVE;
        end
      end else if (slot_kind[idx] == SLOT_TOMB) begin
        if (!seen_tomb) begin
          seen_tomb = 1'b1;
          tomb_at   = idx;
        end
      end else begin
        where = seen_tomb ? tomb_at : idx;
        return seen_tomb ? WALK_TOMB : WALK_EMPTY;
      end
      idx = (idx + 1) % SLOTS;
    end
    where = tomb_at;
    return seen_tomb ? WALK_TOMB : WALK_NONE;
  endfunction

  // Apply one request to the mirror and return the response it should produce.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t        res;
    walk_end_t   hit;
    int unsigned where;
    res.status     = STATUS_NOT_FOUND;
    res.is_new_key = 1'b0;
    res.value_out  = '0;
    case (r.req_type)
      REQ_SET: begin
        // The load check comes before any probing, so even overwrites are refused.
        if (int'(occ_count) + 1 > int'(occ_limit)) begin
          res.status = STATUS_FULL;
        end else begin
          hit = walk_table(r.key_id, r.key_hash, where);
          if (hit == WALK_NONE) begin
            res.status = STATUS_FULL;
          end else begin
            if (hit == WALK_EMPTY) occ_count = occ_count + 9'd1;
            res.is_new_key  = (hit != WALK_LIVE);
            slot_kind[where] = SLOT_LIVE;
            slot_key[where]  = r.key_id;
            slot_val[where]  = r.value_in;
            res.status       = STATUS_OK;
          end
        end
      end
      REQ_GET: begin
        hit = walk_table(r.key_id, r.key_hash, where);
        if (hit == WALK_LIVE) begin
          res.status    = STATUS_OK;
          res.value_out = slot_val[where];
        end
      end
      REQ_DEL: begin
        hit = walk_table(r.key_id, r.key_hash, where);
        if (hit == WALK_LIVE) begin
          slot_kind[where] = SLOT_TOMB;
          res.status       = STATUS_OK;
        end
      end
      default: begin
        // The unused code is answered as not found and touches nothing.
      end
    endcase
    res.occupancy = occ_count;
    return res;
  endfunction

  // Count a failure and describe the first few in full.
  task automatic report(input string what, input rsp_t want, input rsp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected status %0d new %0d value %h occ %0d",
               $realtime, what, want.status, want.is_new_key, want.value_out, want.occupancy);
      $display("%0t: %s: got      status %0d new %0d value %h occ %0d",
               $realtime, what, got.status, got.is_new_key, got.value_out, got.occupancy);
    end
  endtask

  // Sample both channels and the register port on every rising edge.
  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      for (int unsigned i = 0; i < SLOTS; i++) begin
        slot_kind[i] = SLOT_EMPTY;
        slot_key[i]  = '0;
        slot_val[i]  = '0;
      end
      occ_count = '0;
      occ_limit = MAX_OCC_RESET;
      awaited_q.delete();
    end else begin
      if (done) begin
        responses++;
        if (awaited_q.size() == 0) begin
          report("response with no request waiting", '0, rsp);
        end else begin
          want = awaited_q.pop_front();
          if (rsp.status !== want.status || rsp.is_new_key !== want.is_new_key ||
              rsp.value_out !== want.value_out || rsp.occupancy !== want.occupancy) begin
            report("response mismatch", want, rsp);
          end
        end
      end
      if (cfg_we) occ_limit = cfg_wdata;
      if (start && !busy) awaited_q.push_back(apply_request(req));
    end
    outstanding = awaited_q.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench top for the hash map: clock, reset, request stimulus, limit writes and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lhm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned POOL_N   = 48;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        done;
  rsp_t        rsp;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned responses;
  int unsigned sent;

  // Keys reused through a phase, each with a fixed hash crowded into a narrow slot window.
  logic [31:0] pool_key  [POOL_N];
  logic [31:0] pool_hash [POOL_N];

  linear_probe_hash_map uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .rsp       (rsp)
  );

  lhm_checker chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .responses   (responses)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #15_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic req_t make_req(input logic [1:0] op, input logic [31:0] key,
                                    input logic [31:0] hash, input logic [63:0] val);
    req_t r;
    r.req_type = op;
    r.key_id   = key;
    r.key_hash = hash;
    r.value_in = val;
    return r;
  endfunction

  // Hold the request with start high until the block takes it, then drop start.
  task automatic send_request(input req_t r);
    start = 1'b1;
    req   = r;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    sent++;
  endtask

  // The sender stays idle in each cycle with the given percentage.
  task automatic pause_sender(input int unsigned pct);
    while ($urandom_range(99) < pct) @(negedge clk);
  endtask

  // Wait until every response has come back and the block is quiet.
  task automatic wait_until_drained();
    while (outstanding != 0 || busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] lim);
    wait_until_drained();
    cfg_we    = 1'b1;
    cfg_wdata = lim;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic new_key_pool();
    int unsigned base;
    logic [31:0] h;
    base = $urandom_range(255);
    for (int unsigned i = 0; i < POOL_N; i++) begin
      h      = $urandom;
      h[7:0] = 8'(base + $urandom_range(23));
      // Some keys share a hash outright so that their walks collide.
      if (i > 0 && $urandom_range(3) == 0) h = pool_hash[i-1];
      pool_key[i]  = $urandom;
      pool_hash[i] = h;
    end
  endtask

  // Mostly pooled keys, with a few fresh keys and the odd unused request code.
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    int unsigned slot;
    pick       = $urandom_range(99);
    slot       = $urandom_range(POOL_N - 1);
    r.key_id   = pool_key[slot];
    r.key_hash = pool_hash[slot];
    r.value_in = {$urandom, $urandom};
    if (pick < 5)       r.req_type = REQ_UNUSED;
    else if (pick < 48) r.req_type = REQ_SET;
    else if (pick < 76) r.req_type = REQ_GET;
    else                r.req_type = REQ_DEL;
    if ($urandom_range(99) < 12) begin
      r.key_id   = $urandom;
      r.key_hash = $urandom;
    end
    return r;
  endfunction

  // One random phase: two limit settings, a sender idle rate, occasional full drains.
  task automatic run_phase(input int unsigned pct, input logic [7:0] lim_a,
                           input logic [7:0] lim_b, input int unsigned per_half);
    new_key_pool();
    for (int unsigned half = 0; half < 2; half++) begin
      write_limit(half == 0 ? lim_a : lim_b);
      for (int unsigned i = 0; i < per_half; i++) begin
        if ($urandom_range(99) < 3) wait_until_drained();
        pause_sender(pct);
        send_request(random_request());
      end
    end
  endtask

  initial begin
    int unsigned directed;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    sent      = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset limit: key zero, extreme keys and values, wrap at the top slot.
    send_request(make_req(REQ_SET, 32'h0, 32'h0, 64'h0));
    send_request(make_req(REQ_GET, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_req(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_req(REQ_SET, 32'h1, 32'hFFFF_FFFF, 64'hA5A5_5A5A_0F0F_F0F0));
    send_request(make_req(REQ_GET, 32'h1, 32'hFFFF_FFFF, 64'h0));
    // A tombstone in the top slot must not hide the key stored past it.
    send_request(make_req(REQ_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0));
    send_request(make_req(REQ_GET, 32'h1, 32'hFFFF_FFFF, 64'h0));
    send_request(make_req(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0));
    send_request(make_req(REQ_SET, 32'h2, 32'h0000_00FF, 64'h1234_5678_9ABC_DEF0));
    send_request(make_req(REQ_SET, 32'h1, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF));
    send_request(make_req(REQ_DEL, 32'h1, 32'hFFFF_FFFF, 64'h0));
    send_request(make_req(REQ_SET, 32'h1, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001));
    send_request(make_req(REQ_DEL, 32'h7, 32'h7, 64'h0));
    send_request(make_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_req(REQ_GET, 32'h2, 32'h0000_00FF, 64'h0));

    // Limit just above the count: one more key fits, then the load check refuses even overwrites.
    write_limit(8'd4);
    send_request(make_req(REQ_SET, 32'h3, 32'h10, 64'h5555_5555_5555_5555));
    send_request(make_req(REQ_SET, 32'h4, 32'h11, 64'h1));
    send_request(make_req(REQ_SET, 32'h3, 32'h10, 64'h2));
    send_request(make_req(REQ_GET, 32'h3, 32'h10, 64'h0));
    // A zero limit refuses every set; lookups carry on.
    write_limit(8'd0);
    send_request(make_req(REQ_SET, 32'h3, 32'h10, 64'h3));
    send_request(make_req(REQ_GET, 32'h0, 32'h0, 64'h0));
    write_limit(8'd1);
    send_request(make_req(REQ_SET, 32'h9, 32'h20, 64'h4));
    send_request(make_req(REQ_DEL, 32'h3, 32'h10, 64'h0));
    directed = sent;

    // Random phases: sender idle in about a fifth of its cycles, then in most, then never.
    run_phase(22, 8'd40, 8'd96, 275);
    run_phase(61, 8'd160, 8'd255, 275);
    run_phase(0, 8'd200, 8'd255, 275);

    wait_until_drained();
    repeat (300) @(negedge clk);

    $display("Ran %0d requests, %0d directed, the rest random at three sender idle rates.",
             sent, directed);
    $display("Checked %0d responses with the occupancy limit stepped from 192 to 0 and to 255.",
             responses);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
